// ----- rtl/ppt_pkg.sv -----
`default_nettype none
package ppt_pkg;

	// fraction bits of the coordinate format
	localparam int FRAC_BITS = 10;

	localparam int COORD_W = 16;
	localparam int SQ_W    = 2 * COORD_W - 1;
	localparam int DIST_W  = 2 * COORD_W;
	localparam int CFG_W   = 15;
	localparam int CFG2_W  = 2 * CFG_W;
	localparam int NUM_W   = DIST_W + FRAC_BITS;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_W-1:0]   LOOKAHEAD_RST = 15'd512;
	localparam logic [COORD_W-1:0] CRUISE_RST    = 16'd307;
	localparam logic [CFG_W-1:0]   GOAL_TOL_RST  = 15'd102;

	localparam logic [1:0] REG_LOOKAHEAD = 2'd0;
	localparam logic [1:0] REG_CRUISE    = 2'd1;
	localparam logic [1:0] REG_GOAL_TOL  = 2'd2;

	localparam logic [1:0] STAT_TRACK = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_GOAL  = 2'd2;

	typedef enum logic [1:0] {
		JOB_TRACK,
		JOB_EMPTY,
		JOB_GOAL
	} job_kind_t;

	typedef struct packed {
		job_kind_t                  kind;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} back_state_t;

	typedef struct packed {
		logic pop;
		logic mul_en;
		logic prep_en;
		logic div_en;
		logic out_load;
	} back_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/pure_pursuit_steering.sv -----
`default_nettype none
// Pure pursuit steering. Path points stream in at one per cycle unless stalled; each is squared and
// checked against the lookahead and goal radii in the cycle after it is taken, and the first point at
// or beyond the lookahead is kept as the carrot. A last point or an empty-path point hands one job
// to a two-entry queue, and the command unit behind it gives one command per path. Stop commands
// go from idle straight to done in that unit; a tracking command passes through the multiply and
// prepare states and, unless the target is at the origin, the bit-serial divider for 2*v*y/(x*x+y*y).
// The point stream only stalls when a path ends while the queue already holds two jobs. The
// configuration port is always ready; write it only with the block idle.
module pure_pursuit_steering (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  signed [ppt_pkg::COORD_W-1:0]   point_x,
	input  wire  signed [ppt_pkg::COORD_W-1:0]   point_y,
	input  wire                                  last_point,
	input  wire                                  empty_path,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic signed [ppt_pkg::COORD_W-1:0]   linear_cmd,
	output logic signed [ppt_pkg::COORD_W-1:0]   angular_cmd,
	output logic        [1:0]                    status,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire         [1:0]                    cfg_index,
	input  wire         [ppt_pkg::COORD_W-1:0]   cfg_data
);
	import ppt_pkg::*;

	logic [CFG_W-1:0]          lookahead_q, goal_tol_q;
	logic signed [COORD_W-1:0] cruise_q;

	logic push, pop, q_full, head_valid;
	job_t push_job, head_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookahead_q <= LOOKAHEAD_RST;
			cruise_q    <= CRUISE_RST;
			goal_tol_q  <= GOAL_TOL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LOOKAHEAD: lookahead_q <= cfg_data[CFG_W-1:0];
				REG_CRUISE:    cruise_q    <= cfg_data;
				REG_GOAL_TOL:  goal_tol_q  <= cfg_data[CFG_W-1:0];
				default:       ;
			endcase
		end
	end

	ppt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.point_x    (point_x),
		.point_y    (point_y),
		.last_point (last_point),
		.empty_path (empty_path),
		.lookahead  (lookahead_q),
		.goal_tol   (goal_tol_q),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	ppt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	ppt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_job    (head_job),
		.pop         (pop),
		.cruise      (cruise_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.linear_cmd  (linear_cmd),
		.angular_cmd (angular_cmd),
		.status      (status)
	);

endmodule
`default_nettype wire

// ----- rtl/ppt_front.sv -----
`default_nettype none
module ppt_front (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  signed [ppt_pkg::COORD_W-1:0]   point_x,
	input  wire  signed [ppt_pkg::COORD_W-1:0]   point_y,
	input  wire                                  last_point,
	input  wire                                  empty_path,
	input  wire         [ppt_pkg::CFG_W-1:0]     lookahead,
	input  wire         [ppt_pkg::CFG_W-1:0]     goal_tol,
	input  wire                                  q_full,
	output logic                                 push,
	output ppt_pkg::job_t                        push_job
);
	import ppt_pkg::*;

	logic                       valid_s1_q;
	logic signed [COORD_W-1:0]  x_s1, y_s1;
	logic                       last_s1, empty_s1;
	logic [SQ_W-1:0]            sqx_s1, sqy_s1;
	logic [CFG2_W-1:0]          la2_s1, tol2_s1;

	logic                       found_q;
	logic signed [COORD_W-1:0]  tgt_x_q, tgt_y_q;

	logic signed [DIST_W-1:0]   sqx_c, sqy_c;
	logic [DIST_W-1:0]          d2;
	logic                       need_push, adv, hit;

	assign sqx_c = DIST_W'(point_x) * DIST_W'(point_x);
	assign sqy_c = DIST_W'(point_y) * DIST_W'(point_y);

	assign d2        = DIST_W'(sqx_s1) + DIST_W'(sqy_s1);
	assign hit       = !found_q && (d2 >= DIST_W'(la2_s1));
	assign need_push = empty_s1 || last_s1;
	assign adv       = valid_s1_q && !(need_push && q_full);
	assign in_ready  = !valid_s1_q || adv;
	assign push      = adv && need_push;

	always_comb begin
		push_job.x = found_q ? tgt_x_q : x_s1;
		push_job.y = found_q ? tgt_y_q : y_s1;
		if (empty_s1) begin
			push_job.kind = JOB_EMPTY;
		end else if (!found_q && !hit && (d2 < DIST_W'(tol2_s1))) begin
			push_job.kind = JOB_GOAL;
		end else begin
			push_job.kind = JOB_TRACK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (in_ready) begin
			valid_s1_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_s1     <= point_x;
			y_s1     <= point_y;
			last_s1  <= last_point;
			empty_s1 <= empty_path;
			sqx_s1   <= SQ_W'(sqx_c);
			sqy_s1   <= SQ_W'(sqy_c);
			la2_s1   <= CFG2_W'(lookahead) * CFG2_W'(lookahead);
			tol2_s1  <= CFG2_W'(goal_tol) * CFG2_W'(goal_tol);
		end
	end

	// latch the carrot point; drop it at the end of each path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			tgt_x_q <= '0;
			tgt_y_q <= '0;
		end else if (adv) begin
			if (need_push) begin
				found_q <= 1'b0;
				tgt_x_q <= '0;
				tgt_y_q <= '0;
			end else if (hit) begin
				found_q <= 1'b1;
				tgt_x_q <= x_s1;
				tgt_y_q <= y_s1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/ppt_queue.sv -----
`default_nettype none
module ppt_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  ppt_pkg::job_t  push_job,
	input  wire            pop,
	output logic           full,
	output logic           head_valid,
	output ppt_pkg::job_t  head_job
);
	import ppt_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
		bump = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/ppt_back.sv -----
`default_nettype none
module ppt_back (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  head_valid,
	input  ppt_pkg::job_t                        head_job,
	output logic                                 pop,
	input  wire  signed [ppt_pkg::COORD_W-1:0]   cruise,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic signed [ppt_pkg::COORD_W-1:0]   linear_cmd,
	output logic signed [ppt_pkg::COORD_W-1:0]   angular_cmd,
	output logic        [1:0]                    status
);
	import ppt_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	back_state_t               state_q, state_d;
	back_ctrl_t                ctrl;

	job_t                      job_q;
	logic signed [COORD_W-1:0] v_q;
	logic [SQ_W-1:0]           sqx_q, sqy_q;
	logic signed [DIST_W-1:0]  prod_q;
	logic [DIST_W-1:0]         den_q;
	logic [NUM_W-1:0]          num_q;
	logic [DIST_W:0]           rem_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      neg_q;

	logic                      out_valid_q;
	logic signed [COORD_W-1:0] linear_q, angular_q;
	logic [1:0]                status_q;

	logic signed [DIST_W-1:0]  sqx_c, sqy_c, prod_c;
	logic [DIST_W-1:0]         den_c;
	logic signed [DIST_W:0]    twice_c;
	logic [DIST_W:0]           abs_c;
	logic [DIST_W:0]           trial, rem_next;
	logic                      ge;
	logic                      slot_free;
	logic signed [COORD_W-1:0] ang_sat, lin_res, ang_res;
	logic [1:0]                stat_res;

	assign sqx_c  = DIST_W'(job_q.x) * DIST_W'(job_q.x);
	assign sqy_c  = DIST_W'(job_q.y) * DIST_W'(job_q.y);
	assign prod_c = DIST_W'(v_q) * DIST_W'(job_q.y);

	assign den_c   = DIST_W'(sqx_q) + DIST_W'(sqy_q);
	assign twice_c = (DIST_W+1)'(prod_q) <<< 1;
	assign abs_c   = twice_c[DIST_W] ? (DIST_W+1)'(-twice_c) : (DIST_W+1)'(twice_c);

	// one restoring step per cycle: shift in the next numerator bit, trial subtract
	assign trial    = {rem_q[DIST_W-1:0], num_q[NUM_W-1]};
	assign ge       = (trial >= {1'b0, den_q});
	assign rem_next = ge ? trial - {1'b0, den_q} : trial;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		if (neg_q) begin
			ang_sat = (num_q > NUM_W'(32768)) ? -16'sd32768
				: COORD_W'(~num_q[COORD_W-1:0] + COORD_W'(1));
		end else begin
			ang_sat = (num_q > NUM_W'(32767)) ? 16'sd32767 : COORD_W'(num_q[COORD_W-1:0]);
		end
	end

	always_comb begin
		case (job_q.kind)
			JOB_TRACK: begin
				lin_res  = v_q;
				ang_res  = ang_sat;
				stat_res = STAT_TRACK;
			end
			JOB_EMPTY: begin
				lin_res  = '0;
				ang_res  = '0;
				stat_res = STAT_EMPTY;
			end
			JOB_GOAL: begin
				lin_res  = '0;
				ang_res  = '0;
				stat_res = STAT_GOAL;
			end
			default: begin
				lin_res  = '0;
				ang_res  = '0;
				stat_res = STAT_GOAL;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					state_d = (head_job.kind == JOB_TRACK) ? ST_MUL : ST_DONE;
				end
			end
			ST_MUL:  state_d = ST_PREP;
			ST_PREP: state_d = (den_c == '0) ? ST_DONE : ST_DIV;
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE:  ctrl.pop      = head_valid;
			ST_MUL:   ctrl.mul_en   = 1'b1;
			ST_PREP:  ctrl.prep_en  = 1'b1;
			ST_DIV:   ctrl.div_en   = 1'b1;
			ST_DONE:  ctrl.out_load = slot_free;
			default:  ctrl = '0;
		endcase
	end

	assign pop = ctrl.pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			job_q <= head_job;
			v_q   <= cruise;
		end
		if (ctrl.mul_en) begin
			sqx_q  <= SQ_W'(sqx_c);
			sqy_q  <= SQ_W'(sqy_c);
			prod_q <= prod_c;
		end
		if (ctrl.prep_en) begin
			den_q <= den_c;
			neg_q <= twice_c[DIST_W];
			rem_q <= '0;
			cnt_q <= CNT_W'(NUM_W - 1);
			// a target at the origin leaves a zero quotient
			num_q <= (den_c == '0) ? '0 : NUM_W'(abs_c[DIST_W-1:0]) << FRAC_BITS;
		end
		if (ctrl.div_en) begin
			rem_q <= rem_next;
			num_q <= {num_q[NUM_W-2:0], ge};
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (ctrl.out_load) begin
			linear_q  <= lin_res;
			angular_q <= ang_res;
			status_q  <= stat_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign linear_cmd  = linear_q;
	assign angular_cmd = angular_q;
	assign status      = status_q;

endmodule
`default_nettype wire

// ----- rtl/ppt_checker.sv -----
`default_nettype none
module ppt_checker (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 out_valid,
	input wire                                 out_ready,
	input wire signed [ppt_pkg::COORD_W-1:0]   linear_cmd,
	input wire signed [ppt_pkg::COORD_W-1:0]   angular_cmd,
	input wire        [1:0]                    status
);
	import ppt_pkg::*;

	// hold a stalled command
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(linear_cmd)
			&& $stable(angular_cmd) && $stable(status))
		else $error("command changed while stalled");

	a_empty_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_EMPTY |-> linear_cmd == '0 && angular_cmd == '0)
		else $error("empty path stop with nonzero command");

	a_goal_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_GOAL |-> linear_cmd == '0 && angular_cmd == '0)
		else $error("goal stop with nonzero command");

endmodule

bind pure_pursuit_steering ppt_checker u_ppt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.linear_cmd  (linear_cmd),
	.angular_cmd (angular_cmd),
	.status      (status)
);
`default_nettype wire
